>>> rtl/fsne_pkg.sv
// Shared types, constants and character helpers for the short-name encoder.
// Used by the front, queue, back and top-level modules.
package fsne_pkg;

  localparam int BASE_LEN = 8;
  localparam int EXT_LEN  = 3;
  localparam int NAME_LEN = BASE_LEN + EXT_LEN;
  localparam int QDEPTH   = 2;
  localparam int QIDX_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int BIDX_W   = $clog2(BASE_LEN);
  localparam int POS_W    = $clog2(NAME_LEN);

  localparam logic [7:0] PAD_CHAR = 8'h20;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] END_CHAR = 8'h00;

  typedef enum logic [2:0] {
    PH_BASE = 3'b001,
    PH_FULL = 3'b010,
    PH_EXT  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [NAME_LEN-1:0][7:0] bytes;
    logic [1:0]               flags;
  } name_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return is_lower(c) ? (c - 8'h20) : c;
  endfunction

endpackage

>>> rtl/fsne_front.sv
// Front end: accepts name characters, tracks base/extension phase and case flags.
// Hands a finished, space-padded name record to the queue. Depends on fsne_pkg.
module fsne_front import fsne_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  logic [7:0] ch,
  input  q_status_t q_status,
  output logic      push,
  output name_rec_t push_rec
);

  phase_t                   phase, phase_next;
  logic [3:0]               base_count, base_count_next;
  logic [1:0]               ext_count, ext_count_next;
  logic                     base_has_letter, base_has_letter_next;
  logic                     base_all_lower, base_all_lower_next;
  logic                     ext_has_letter, ext_has_letter_next;
  logic                     ext_all_lower, ext_all_lower_next;
  logic [NAME_LEN-1:0][7:0] name_buffer;

  logic       accept, is_end, is_dot, lower_c, upper_c;
  logic       wr_base, wr_ext, store_ext;
  logic [7:0] up_c;

  assign item_stall = q_status.full;
  assign accept     = item_valid && !item_stall;
  assign is_end     = (ch == END_CHAR);
  assign is_dot     = (ch == DOT_CHAR);
  assign lower_c    = is_lower(ch);
  assign upper_c    = is_upper(ch);
  assign up_c       = to_upper(ch);
  assign store_ext  = wr_ext && (ext_count != 2'(EXT_LEN));
  assign push       = accept && is_end;

  always_comb begin
    phase_next           = phase;
    base_count_next      = base_count;
    ext_count_next       = ext_count;
    base_has_letter_next = base_has_letter;
    base_all_lower_next  = base_all_lower;
    ext_has_letter_next  = ext_has_letter;
    ext_all_lower_next   = ext_all_lower;
    wr_base              = 1'b0;
    wr_ext               = 1'b0;
    if (accept) begin
      if (is_end) begin
        phase_next           = PH_BASE;
        base_count_next      = '0;
        ext_count_next       = '0;
        base_has_letter_next = 1'b0;
        base_all_lower_next  = 1'b1;
        ext_has_letter_next  = 1'b0;
        ext_all_lower_next   = 1'b1;
      end else begin
        unique case (phase)
          PH_BASE: begin
            if (is_dot) begin
              phase_next = PH_EXT;
            end else begin
              wr_base         = 1'b1;
              base_count_next = base_count + 4'd1;
              if (base_count == 4'(BASE_LEN - 1)) begin
                phase_next = PH_FULL;
              end
            end
          end
          PH_FULL: begin
            phase_next = PH_EXT;
            wr_ext     = !is_dot;
          end
          PH_EXT: begin
            wr_ext = 1'b1;
          end
          default: begin
            phase_next = PH_EXT;
            wr_ext     = 1'b1;
          end
        endcase
        if (wr_base) begin
          if (lower_c) begin
            base_has_letter_next = 1'b1;
          end else if (upper_c) begin
            base_has_letter_next = 1'b1;
            base_all_lower_next  = 1'b0;
          end
        end
        if (store_ext) begin
          ext_count_next = ext_count + 2'd1;
          if (lower_c) begin
            ext_has_letter_next = 1'b1;
          end else if (upper_c) begin
            ext_has_letter_next = 1'b1;
            ext_all_lower_next  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_BASE;
      base_count      <= '0;
      ext_count       <= '0;
      base_has_letter <= 1'b0;
      base_all_lower  <= 1'b1;
      ext_has_letter  <= 1'b0;
      ext_all_lower   <= 1'b1;
    end else begin
      phase           <= phase_next;
      base_count      <= base_count_next;
      ext_count       <= ext_count_next;
      base_has_letter <= base_has_letter_next;
      base_all_lower  <= base_all_lower_next;
      ext_has_letter  <= ext_has_letter_next;
      ext_all_lower   <= ext_all_lower_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BASE_LEN; i++) begin
      if (wr_base && (base_count[BIDX_W-1:0] == BIDX_W'(i))) begin
        name_buffer[i] <= up_c;
      end
    end
    for (int i = 0; i < EXT_LEN; i++) begin
      if (store_ext && (ext_count == 2'(i))) begin
        name_buffer[BASE_LEN + i] <= up_c;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < BASE_LEN; i++) begin
      push_rec.bytes[i] = (4'(i) < base_count) ? name_buffer[i] : PAD_CHAR;
    end
    for (int i = 0; i < EXT_LEN; i++) begin
      push_rec.bytes[BASE_LEN + i] = (2'(i) < ext_count) ? name_buffer[BASE_LEN + i]
                                                          : PAD_CHAR;
    end
    push_rec.flags = {ext_has_letter && ext_all_lower, base_has_letter && base_all_lower};
  end

endmodule

>>> rtl/fsne_queue.sv
// Small FIFO of finished name records between front and back end.
// Depends on fsne_pkg for the record type and depth.
module fsne_queue import fsne_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  name_rec_t push_rec,
  input  logic      pop,
  output name_rec_t head,
  output q_status_t q_status
);

  name_rec_t           entries [QDEPTH];
  logic [QIDX_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign q_status.full  = (count == QCNT_W'(QDEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QIDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QIDX_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

>>> rtl/fsne_back.sv
// Back end: serializes one name record into eleven result transfers.
// Holds the output register; depends on fsne_pkg.
module fsne_back import fsne_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  name_rec_t        head,
  input  q_status_t        q_status,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [7:0]       out_byte,
  output logic [POS_W-1:0] position,
  output logic [1:0]       case_flags,
  output logic             last
);

  logic [POS_W-1:0] idx;
  logic             load, at_end;

  assign load   = !q_status.empty && (!result_valid || !result_stall);
  assign at_end = (idx == POS_W'(NAME_LEN - 1));
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx          <= at_end ? '0 : idx + POS_W'(1);
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.bytes[idx];
      position   <= idx;
      last       <= at_end;
      case_flags <= at_end ? head.flags : 2'b00;
    end
  end

endmodule

>>> rtl/fat_short_name_encoder_unit.sv
// FAT 8.3 short-name encoder top level: front end, record queue, back end.
// Depends on fsne_pkg, fsne_front, fsne_queue and fsne_back.
//
// Input channel (item_valid / item_stall / ch): one name byte per transfer,
// a zero byte ends the name. Characters are taken one per cycle.
// Result channel (result_valid / result_stall / out_byte, position,
// case_flags, last): eleven transfers per name, positions 0..10, space
// padded, case_flags meaningful on the last transfer only.
// A name's record enters the queue on its terminator transfer; the back
// end loads the first result into its output register once that record
// is at the head; the rest follow one per cycle while not stalled.
// Throughput: one character per cycle in unless item_stall is high; one
// result per cycle out unless stalled. A two-entry record queue between
// the front and the back lets the front keep taking characters while the
// output drains; item_stall rises only while both entries are occupied.
// A stalled result holds its payload; the back end waits on the stall.
// Reset (rst, synchronous) empties the queue, drops any partial name and
// clears result_valid.
module fat_short_name_encoder_unit import fsne_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] ch,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [3:0] position,
  output logic [1:0] case_flags,
  output logic       last
);

  name_rec_t push_rec, head;
  q_status_t q_status;
  logic      push, pop;

  fsne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .ch         (ch),
    .q_status   (q_status),
    .push       (push),
    .push_rec   (push_rec)
  );

  fsne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  fsne_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .position     (position),
    .case_flags   (case_flags),
    .last         (last)
  );

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> position == 4'(NAME_LEN - 1))
    else $error("last transfer not at final position");

  a_flags_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> case_flags == 2'b00)
    else $error("case flags set before last transfer");

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(result_valid && !result_stall && !last)
    |-> result_valid && position == $past(position) + 4'd1)
    else $error("result position did not advance by one");

endmodule

>>> test/tb_fat_short_name_encoder_unit.sv
// Testbench for fat_short_name_encoder_unit: directed and random file names go in,
// and each 11-byte short name that comes out is checked against a built-in encoder model.
// Depends on fsne_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_fat_short_name_encoder_unit;
  import fsne_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 88;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] byte_val;
    logic [3:0] pos;
    logic [1:0] flags;
    logic       last_flag;
  } short_name_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [7:0] ch = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte;
  logic [3:0] position;
  logic [1:0] case_flags;
  logic       last;

  logic [7:0]       pending_chars[$];
  short_name_byte_t expected_bytes[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;

  // encoder model state
  logic [7:0]  name_buf[NAME_LEN];
  int unsigned base_cnt;
  int unsigned ext_cnt;
  phase_t      name_phase;
  bit          base_lettered;
  bit          base_all_lower;
  bit          ext_lettered;
  bit          ext_all_lower;

  fat_short_name_encoder_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .ch           (ch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .position     (position),
    .case_flags   (case_flags),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  task automatic clear_name();
    base_cnt       = 0;
    ext_cnt        = 0;
    name_phase     = PH_BASE;
    base_lettered  = 1'b0;
    base_all_lower = 1'b1;
    ext_lettered   = 1'b0;
    ext_all_lower  = 1'b1;
  endtask

  task automatic store_ext(input logic [7:0] c);
    if (ext_cnt < EXT_LEN) begin
      name_buf[BASE_LEN + ext_cnt] = upcase(c);
      ext_cnt++;
      if (c >= 8'h61 && c <= 8'h7A) begin
        ext_lettered = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
        ext_lettered  = 1'b1;
        ext_all_lower = 1'b0;
      end
    end
  endtask

  task automatic encode_char(input logic [7:0] c);
    short_name_byte_t sb;
    logic [1:0]       flags;
    if (c == END_CHAR) begin
      flags = {ext_lettered && ext_all_lower, base_lettered && base_all_lower};
      for (int i = 0; i < NAME_LEN; i++) begin
        if (i < BASE_LEN) sb.byte_val = (i < base_cnt) ? name_buf[i] : PAD_CHAR;
        else sb.byte_val = (i - BASE_LEN < ext_cnt) ? name_buf[i] : PAD_CHAR;
        sb.pos       = 4'(i);
        sb.last_flag = (i == NAME_LEN - 1);
        sb.flags     = sb.last_flag ? flags : 2'b00;
        expected_bytes.push_back(sb);
      end
      clear_name();
    end else begin
      case (name_phase)
        PH_BASE: begin
          if (c == DOT_CHAR) begin
            name_phase = PH_EXT;
          end else begin
            name_buf[base_cnt] = upcase(c);
            base_cnt++;
            if (c >= 8'h61 && c <= 8'h7A) begin
              base_lettered = 1'b1;
            end else if (c >= 8'h41 && c <= 8'h5A) begin
              base_lettered  = 1'b1;
              base_all_lower = 1'b0;
            end
            if (base_cnt == BASE_LEN) name_phase = PH_FULL;
          end
        end
        PH_FULL: begin
          name_phase = PH_EXT;
          if (c != DOT_CHAR) store_ext(c);
        end
        default: store_ext(c);
      endcase
    end
  endtask

  // mode 0: mostly lower case, 1: mostly upper case, 2: mixed
  function automatic logic [7:0] pick_char(input int unsigned mode, input bit allow_dot);
    logic [7:0]  c;
    int unsigned k;
    k = $urandom_range(99);
    if ((mode == 0 && k < 85) || (mode == 2 && k < 30)) c = 8'(32'h61 + $urandom_range(25));
    else if ((mode == 1 && k < 85) || (mode == 2 && k < 60)) c = 8'(32'h41 + $urandom_range(25));
    else if ($urandom_range(1)) c = 8'(32'h30 + $urandom_range(9));
    else c = 8'($urandom_range(1, 255));
    if (!allow_dot && c == DOT_CHAR) c = 8'h5F;
    return c;
  endfunction

  task automatic add_random_name(inout int unsigned added);
    int unsigned base_len, ext_len, base_mode, ext_mode;
    if ($urandom_range(99) < 80) begin
      base_len  = $urandom_range(10);
      ext_len   = $urandom_range(5);
      base_mode = $urandom_range(2);
      ext_mode  = $urandom_range(2);
      for (int i = 0; i < base_len; i++) pending_chars.push_back(pick_char(base_mode, 1'b0));
      if ($urandom_range(3) != 0) begin
        pending_chars.push_back(DOT_CHAR);
        added++;
      end
      for (int i = 0; i < ext_len; i++) pending_chars.push_back(pick_char(ext_mode, 1'b1));
      added += base_len + ext_len;
    end else begin
      base_len = $urandom_range(14);
      for (int i = 0; i < base_len; i++) pending_chars.push_back(8'($urandom_range(1, 255)));
      added += base_len;
    end
    pending_chars.push_back(END_CHAR);
    added++;
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    pending_chars.push_back(END_CHAR);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) encode_char(ch);
      if (!item_valid || !item_stall) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          ch         <= pending_chars.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    short_name_byte_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_bytes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transfer out_byte %h position %0d", $time, out_byte,
                   position);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.byte_val) begin
            error_count++;
            $display("%0t: out_byte expected %h actual %h", $time, want.byte_val, out_byte);
          end
          if (position !== want.pos) begin
            error_count++;
            $display("%0t: position expected %0d actual %0d", $time, want.pos, position);
          end
          if (case_flags !== want.flags) begin
            error_count++;
            $display("%0t: case_flags expected %b actual %b", $time, want.flags, case_flags);
          end
          if (last !== want.last_flag) begin
            error_count++;
            $display("%0t: last expected %b actual %b", $time, want.last_flag, last);
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fat_short_name_encoder_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned added;
    int unsigned idle_plan[4][2] = '{'{0, 0}, '{51, 0}, '{0, 51}, '{8, 8}};
    logic [7:0]  edge_name[9] = '{8'h01, 8'h7A, 8'h5B, 8'h60, 8'h7B, 8'h40, 8'hFF, 8'h41,
                                  END_CHAR};
    clear_name();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty name, full base with skipped dot, leading dot with dot in extension
    // and overflow, case boundaries and high bytes in a full base
    pending_chars.push_back(END_CHAR);
    add_string("abcdefgh.txt");
    add_string(".a.bcd");
    foreach (edge_name[i]) pending_chars.push_back(edge_name[i]);
    pending_chars.push_back(8'h80);
    add_string("bcdefgHIJ");

    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct  = idle_plan[p][0];
      recv_stall_pct = idle_plan[p][1];
      added = 0;
      while (added < PHASE_ITEMS) add_random_name(added);
      while (pending_chars.size() != 0 || item_valid || expected_bytes.size() != 0)
        @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("fat_short_name_encoder_unit regression: pass");
    end else begin
      $display("fat_short_name_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> fat_short_name_encoder_unit.f
rtl/fsne_pkg.sv
rtl/fsne_front.sv
rtl/fsne_queue.sv
rtl/fsne_back.sv
rtl/fat_short_name_encoder_unit.sv
test/tb_fat_short_name_encoder_unit.sv
